[hw/rtl/erb_pkg.sv]
// Package for the box face extrusion unit: shared types, corner table and widths.
// Depends on nothing; used by the interfaces and all modules but erb_div.
package erb_pkg;

	localparam int unsigned NumCorners = 24;
	localparam int unsigned CornerW = 5;

	// Input word: depth, rectangle sizes and direction, all signed Q16.16.
	typedef struct packed {
		logic signed [31:0] depth;
		logic signed [31:0] size_x;
		logic signed [31:0] size_y;
		logic signed [31:0] dir_i;
		logic signed [31:0] dir_j;
		logic signed [31:0] dir_k;
	} in_word_t;

	// Output word: one corner of one face.
	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [2:0] face_index;
		logic [1:0] corner_index;
		logic last_point;
	} out_word_t;

	// Classified job passed from the front part to the back part.
	typedef struct packed {
		logic signed [31:0] size_x;
		logic signed [31:0] size_y;
		logic [31:0] dmag;
		logic [31:0] mag_i;
		logic [31:0] mag_j;
		logic [31:0] mag_k;
		logic neg_i;
		logic neg_j;
		logic neg_k;
	} job_t;

	// Corner code: bit 0 picks the x extent, bit 1 the y extent, bit 2 the top.
	function automatic logic [2:0] corner_code(input logic [CornerW-1:0] n);
		logic [2:0] c;
		case (n)
			5'd0: c = 3'd0;  5'd1: c = 3'd1;  5'd2: c = 3'd3;  5'd3: c = 3'd2;
			5'd4: c = 3'd1;  5'd5: c = 3'd5;  5'd6: c = 3'd7;  5'd7: c = 3'd3;
			5'd8: c = 3'd2;  5'd9: c = 3'd3;  5'd10: c = 3'd7; 5'd11: c = 3'd6;
			5'd12: c = 3'd0; 5'd13: c = 3'd2; 5'd14: c = 3'd6; 5'd15: c = 3'd4;
			5'd16: c = 3'd0; 5'd17: c = 3'd4; 5'd18: c = 3'd5; 5'd19: c = 3'd1;
			5'd20: c = 3'd4; 5'd21: c = 3'd5; 5'd22: c = 3'd7; 5'd23: c = 3'd6;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

	// Saturate a 34-bit signed sum to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) r = 32'sh7fffffff;
		else if (v < -34'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

[hw/rtl/erb_in_if.sv]
// Input channel interface of the box face extrusion unit.
// Depends on erb_pkg for the word type.
interface erb_in_if;
	logic valid;
	logic ready;
	erb_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/erb_out_if.sv]
// Output channel interface of the box face extrusion unit.
// Depends on erb_pkg for the word type.
interface erb_out_if;
	logic valid;
	logic ready;
	erb_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/extrude_rectangle_to_box_faces_unit.sv]
// Top level of the box face extrusion unit.
// Depends on erb_pkg, erb_in_if, erb_out_if, erb_front and erb_back.

// Each accepted word yields 24 corner words (none when depth or direction is zero).
// One job runs through the sums of squares, a bitwise square root, three divisions
// on the one shared divider and then the emission of its 24 corners; a two-entry
// queue lets input words be taken while a job runs. Each corner word is loaded into
// the output register only when the output channel can take a new word.
module extrude_rectangle_to_box_faces_unit (
	input logic clk,
	input logic arst_n,
	erb_in_if.sink in_ch,
	erb_out_if.source out_ch
);

	logic job_valid;
	logic job_pop;
	erb_pkg::job_t job;

	erb_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.job_valid(job_valid), .job(job), .job_pop(job_pop)
	);

	erb_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.job_pop(job_pop), .out_ch(out_ch)
	);

endmodule

[hw/rtl/erb_front.sv]
// Front part: accepts input words, drops degenerate ones and queues jobs.
// Depends on erb_pkg and erb_in_if; holds a two-entry job queue.
module erb_front (
	input logic clk,
	input logic arst_n,
	erb_in_if.sink in_ch,
	output logic job_valid,
	output erb_pkg::job_t job,
	input logic job_pop
);

	erb_pkg::job_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q;
	logic wr_q;
	logic push;
	logic keep;
	erb_pkg::job_t nj;

	assign in_ch.ready = (cnt_q != 2'd2);
	// Zero depth or zero direction produces no words and is simply dropped.
	assign keep = (in_ch.data.depth != 32'sd0) &&
		!(in_ch.data.dir_i == 32'sd0 && in_ch.data.dir_j == 32'sd0 &&
		in_ch.data.dir_k == 32'sd0);
	assign push = in_ch.valid && in_ch.ready && keep;

	// Classify: split each signed value into magnitude and sign.
	always_comb begin
		nj.size_x = in_ch.data.size_x;
		nj.size_y = in_ch.data.size_y;
		nj.dmag = in_ch.data.depth[31] ? 32'(-in_ch.data.depth) : in_ch.data.depth;
		nj.mag_i = in_ch.data.dir_i[31] ? 32'(-in_ch.data.dir_i) : in_ch.data.dir_i;
		nj.mag_j = in_ch.data.dir_j[31] ? 32'(-in_ch.data.dir_j) : in_ch.data.dir_j;
		nj.mag_k = in_ch.data.dir_k[31] ? 32'(-in_ch.data.dir_k) : in_ch.data.dir_k;
		nj.neg_i = in_ch.data.dir_i[31];
		nj.neg_j = in_ch.data.dir_j[31];
		nj.neg_k = in_ch.data.dir_k[31];
	end

	// Job queue storage.
	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= nj;
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (job_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(job_pop);
		end
	end

	assign job_valid = (cnt_q != 2'd0);
	assign job = q_q[rd_q];

`ifndef ASSERT_OFF
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid) else $error("pop from empty job queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("job queue overflow");
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && !keep && !job_pop) |=> $stable(cnt_q))
		else $error("dropped word changed queue");
`endif

endmodule

[hw/rtl/erb_div.sv]
// Iterative unsigned divider: 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on nothing outside itself.
module erb_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] num,
	input logic [31:0] den,
	output logic busy,
	output logic [63:0] quo
);

	logic [63:0] n_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [6:0] cnt_q;
	logic [32:0] trial;
	logic [33:0] diff;

	assign trial = {rem_q[31:0], n_q[63]};
	assign diff = {1'b0, trial} - {2'b0, den_q};

	// Restoring division, quotient bits shift in behind the dividend.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			rem_q <= 33'd0;
			den_q <= den;
		end else if (cnt_q != 7'd0) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				n_q <= {n_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				n_q <= {n_q[62:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 7'd0);
	assign quo = n_q;

endmodule

[hw/rtl/erb_back.sv]
// Back part: computes the offset and streams the 24 face corners.
// Depends on erb_pkg, erb_out_if and erb_div (shared divider).
module erb_back (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input erb_pkg::job_t job,
	output logic job_pop,
	erb_out_if.source out_ch
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQ, ST_ROOT, ST_DIV, ST_WAIT, ST_EMIT
	} state_t;

	state_t state_q;
	erb_pkg::job_t job_q;
	logic [1:0] idx_q;
	logic [63:0] acc_q;
	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [31:0] root_q;
	logic [32:0] off_q [3];
	logic [4:0] n_q;
	logic signed [31:0] xs_q [4];
	logic signed [31:0] ys_q [4];
	logic signed [31:0] zt_q;
	logic div_start;
	logic div_busy;
	logic [63:0] div_quo;
	logic [31:0] mag_sel;
	logic [63:0] prod;
	logic [63:0] sum_rb;
	logic [63:0] num;
	logic [2:0] code;
	logic signed [33:0] oi;
	logic signed [33:0] oj;
	logic signed [33:0] ok;
	logic out_take;

	always_comb begin
		case (idx_q)
			2'd0: mag_sel = job_q.mag_i;
			2'd1: mag_sel = job_q.mag_j;
			default: mag_sel = job_q.mag_k;
		endcase
	end

	assign prod = 64'(mag_sel) * 64'(mag_sel);
	assign sum_rb = res_q + bit_q;
	assign num = 64'(mag_sel) * 64'(job_q.dmag) + 64'(root_q[31:1]);
	assign div_start = (state_q == ST_DIV);

	erb_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num),
		.den(root_q), .busy(div_busy), .quo(div_quo)
	);

	// Signed offsets, 34 bits so that a magnitude of 2^31 is kept.
	assign oi = job_q.neg_i ? -$signed({1'b0, off_q[0]}) : $signed({1'b0, off_q[0]});
	assign oj = job_q.neg_j ? -$signed({1'b0, off_q[1]}) : $signed({1'b0, off_q[1]});
	assign ok = job_q.neg_k ? -$signed({1'b0, off_q[2]}) : $signed({1'b0, off_q[2]});

	assign code = erb_pkg::corner_code(n_q);
	assign out_take = !out_ch.valid || out_ch.ready;
	assign job_pop = (state_q == ST_IDLE) && job_valid;

	// Sequencer: sum of squares, bitwise square root, three divisions, emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_ch.valid <= 1'b0;
			idx_q <= 2'd0;
			n_q <= 5'd0;
		end else begin
			// Output valid rises with each emitted word and falls once it is taken.
			if (state_q == ST_EMIT && out_take) out_ch.valid <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_SQ;
						idx_q <= 2'd0;
					end
				end
				ST_SQ: begin
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
					if (idx_q == 2'd2) state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (bit_q == 64'd0) begin
						state_q <= ST_DIV;
						idx_q <= 2'd0;
					end
				end
				ST_DIV: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (!div_busy) begin
						idx_q <= idx_q + 2'd1;
						state_q <= (idx_q == 2'd2) ? ST_EMIT : ST_DIV;
						n_q <= 5'd0;
					end
				end
				ST_EMIT: begin
					if (out_take) begin
						n_q <= n_q + 5'd1;
						if (n_q == 5'(erb_pkg::NumCorners - 1)) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q <= job;
				acc_q <= 64'd0;
			end
			ST_SQ: begin
				acc_q <= acc_q + prod;
				if (idx_q == 2'd2) begin
					rem_q <= acc_q + prod;
					res_q <= 64'd0;
					bit_q <= 64'd1 << 62;
				end
			end
			ST_ROOT: begin
				if (bit_q != 64'd0) begin
					if (rem_q >= sum_rb) begin
						rem_q <= rem_q - sum_rb;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					root_q <= res_q[31:0];
				end
			end
			ST_WAIT: begin
				if (!div_busy && idx_q != 2'd3) off_q[idx_q] <= div_quo[32:0];
			end
			ST_EMIT: begin
				// Corner extents: index bit 1 is top, bit 0 the size select.
				xs_q[0] <= 32'sd0;
				xs_q[1] <= job_q.size_x;
				xs_q[2] <= erb_pkg::sat32(oi);
				xs_q[3] <= erb_pkg::sat32(34'(job_q.size_x) + oi);
				ys_q[0] <= 32'sd0;
				ys_q[1] <= job_q.size_y;
				ys_q[2] <= erb_pkg::sat32(oj);
				ys_q[3] <= erb_pkg::sat32(34'(job_q.size_y) + oj);
				zt_q <= erb_pkg::sat32(ok);
			end
			default: ;
		endcase
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_take) begin
			out_ch.data.point_x <= n_q == 5'd0 ? 32'sd0 : xs_q[{code[2], code[0]}];
			out_ch.data.point_y <= n_q == 5'd0 ? 32'sd0 : ys_q[{code[2], code[1]}];
			out_ch.data.point_z <= code[2] ? zt_q : 32'sd0;
			out_ch.data.face_index <= 3'(n_q >> 2);
			out_ch.data.corner_index <= n_q[1:0];
			out_ch.data.last_point <= (n_q == 5'(erb_pkg::NumCorners - 1));
		end
	end

`ifndef ASSERT_OFF
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.data.last_point) |->
		out_ch.data.face_index == 3'd5) else $error("last word not on top face");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> out_ch.valid)
		else $error("output word lost");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");
`endif

endmodule

[tb/sv/erb_box_checker.sv]
// Checker for the box face extrusion unit: predicts the 24 corners of each accepted
// word of nonzero depth and direction; compares with the output. Depends on erb_pkg.
`timescale 1ns / 1ps
module erb_box_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input erb_pkg::in_word_t in_data,
	input logic out_valid,
	input logic out_ready,
	input erb_pkg::out_word_t out_data,
	output int errors,
	output int pending,
	output int corners_seen,
	output int boxes_seen
);

	erb_pkg::out_word_t corner_queue[$];
	int err_n = 0;
	int pend_n = 0;
	int corner_n = 0;
	int box_n = 0;

	assign errors = err_n;
	assign pending = pend_n;
	assign corners_seen = corner_n;
	assign boxes_seen = box_n;

	// Integer square root by the bitwise method.
	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Signed offset component, magnitude rounded half away from zero.
	function automatic longint offset_part(input longint c, input logic [63:0] d,
			input logic [63:0] r);
		logic [63:0] m;
		logic [63:0] mc;
		mc = (c < 0) ? -c : c;
		m = (mc * d + (r >> 1)) / r;
		return (c < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Queue the corners of one box in emission order.
	task automatic predict_box(input erb_pkg::in_word_t w);
		logic [2:0] codes [24];
		longint dep, di, dj, dk, oi, oj, ok;
		logic [63:0] dm, s, r;
		logic signed [31:0] xs[2][2], ys[2][2], zs[2];
		erb_pkg::out_word_t o;
		codes = '{0,1,3,2, 1,5,7,3, 2,3,7,6, 0,2,6,4, 0,4,5,1, 4,5,7,6};
		dep = w.depth;
		di = w.dir_i;
		dj = w.dir_j;
		dk = w.dir_k;
		if (dep == 0 || (di == 0 && dj == 0 && dk == 0)) return;
		dm = (dep < 0) ? -dep : dep;
		s = di * di + dj * dj + dk * dk;
		r = root_floor(s);
		oi = offset_part(di, dm, r);
		oj = offset_part(dj, dm, r);
		ok = offset_part(dk, dm, r);
		xs[0][0] = 0; xs[0][1] = w.size_x;
		xs[1][0] = clamp32(oi); xs[1][1] = clamp32(longint'(w.size_x) + oi);
		ys[0][0] = 0; ys[0][1] = w.size_y;
		ys[1][0] = clamp32(oj); ys[1][1] = clamp32(longint'(w.size_y) + oj);
		zs[0] = 0; zs[1] = clamp32(ok);
		for (int n = 0; n < 24; n++) begin
			o.point_x = xs[codes[n][2]][codes[n][0]];
			o.point_y = ys[codes[n][2]][codes[n][1]];
			o.point_z = zs[codes[n][2]];
			o.face_index = 3'(n / 4);
			o.corner_index = 2'(n % 4);
			o.last_point = (n == 23);
			corner_queue = {corner_queue, o};
		end
	endtask

	// Sample both channels at the clock edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) predict_box(in_data);
			if (out_valid && out_ready) begin
				corner_n++;
				if (out_data.last_point) box_n++;
				if (corner_queue.size() == 0) begin
					err_n++;
					$display("%0t: unexpected corner word %h", $time, out_data);
				end else begin
					erb_pkg::out_word_t e;
					e = corner_queue.pop_front();
					if (e !== out_data) begin
						err_n++;
						$display("%0t: corner mismatch expected x=%h y=%h z=%h f=%0d c=%0d l=%0d",
							$time, e.point_x, e.point_y, e.point_z, e.face_index,
							e.corner_index, e.last_point);
						$display("%0t:                  actual x=%h y=%h z=%h f=%0d c=%0d l=%0d",
							$time, out_data.point_x, out_data.point_y, out_data.point_z,
							out_data.face_index, out_data.corner_index, out_data.last_point);
					end
				end
			end
			pend_n = corner_queue.size();
		end
	end
endmodule

[tb/sv/extrude_rectangle_to_box_faces_unit_tb.sv]
// Testbench top for the box face extrusion unit: drives input words and output
// stalls, and gives the verdict. Depends on erb_pkg, both interfaces and erb_box_checker.
`timescale 1ns / 1ps
module extrude_rectangle_to_box_faces_unit_tb;

	logic clk;
	logic arst_n;
	int errors, pending, corners_seen, boxes_seen;
	int cycles;
	bit words_done;
	bit hold_long;

	erb_in_if in_ch ();
	erb_out_if out_ch ();

	extrude_rectangle_to_box_faces_unit uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	erb_box_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.errors(errors), .pending(pending),
		.corners_seen(corners_seen), .boxes_seen(boxes_seen)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
	end

	// Pick a field value, leaning toward the extremes.
	function automatic logic [31:0] pick_field();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return 32'(int'($urandom_range(0, 8)) - 4) << 16;
			4: return $urandom_range(0, 3) - 1;
			default: return $urandom();
		endcase
	endfunction

	// Offer one word and hold it until it is accepted; valid drops only for a gap.
	task automatic send_word(input erb_pkg::in_word_t w);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= w;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	function automatic erb_pkg::in_word_t make_word(input logic [31:0] d,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] i,
			input logic [31:0] j, input logic [31:0] k);
		erb_pkg::in_word_t w;
		w.depth = d; w.size_x = x; w.size_y = y;
		w.dir_i = i; w.dir_j = j; w.dir_k = k;
		return w;
	endfunction

	// Stimulus: directed corner cases, then random words.
	initial begin
		erb_pkg::in_word_t w;
		words_done = 0;
		hold_long = 0;
		in_ch.valid <= 0;
		in_ch.data <= '0;
		@(posedge arst_n);
		@(posedge clk);
		send_word(make_word(32'h0, 32'h10000, 32'h10000, 0, 0, 32'h10000));
		send_word(make_word(32'h10000, 32'h10000, 32'h10000, 0, 0, 0));
		send_word(make_word(32'h20000, 32'h30000, 32'h40000, 0, 0, 32'h10000));
		send_word(make_word(32'hfffe0000, 32'hfffd0000, 32'h40000, 32'h10000,
			32'h10000, 32'h10000));
		send_word(make_word(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			0, 0));
		send_word(make_word(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000));
		send_word(make_word(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0,
			32'h80000000, 0));
		send_word(make_word(32'h80000000, 32'h1, 32'hffffffff, 0, 0, 32'h1));
		send_word(make_word(32'h1, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff,
			32'h1));
		send_word(make_word(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff));
		send_word(make_word(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
			32'h55555555, 32'haaaaaaaa));
		send_word(make_word(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
			32'haaaaaaaa, 32'h55555555));
		// Long receiver hold-off while words keep coming.
		hold_long = 1;
		for (int n = 0; n < 6; n++) begin
			send_word(make_word(32'h50000, $urandom(), $urandom(), 32'h10000, 0,
				32'h10000));
		end
		for (int n = 0; n < 190; n++) begin
			w = make_word(pick_field(), pick_field(), pick_field(), pick_field(),
				pick_field(), pick_field());
			// Most words are well formed so the full box gets emitted.
			if (n % 10 != 0) begin
				if (w.depth == 0) w.depth = $urandom() | 1;
				if (w.dir_k == 0 && w.dir_i == 0) w.dir_j = w.dir_j | 32'h100;
			end
			send_word(w);
		end
		in_ch.valid <= 0;
		words_done = 1;
	end

	// Output stalls; during the hold-off the receiver stays low for a long stretch.
	initial begin
		int wait_n;
		bit held;
		held = 0;
		out_ch.ready <= 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_long && !held) begin
				held = 1;
				out_ch.ready <= 0;
				repeat (3000) @(posedge clk);
			end
			wait_n = $urandom_range(0, 9);
			if ($urandom_range(0, 3) == 0) wait_n = 0;
			if (wait_n != 0) begin
				out_ch.ready <= 0;
				repeat (wait_n) @(posedge clk);
			end
			out_ch.ready <= 1;
			@(posedge clk);
		end
	end

	// Cycle limit guard.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 1500000) begin
				$display("timeout after %0d cycles", cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Verdict once every expected corner has arrived.
	initial begin
		@(posedge arst_n);
		wait (words_done);
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("covered %0d corner words from %0d boxes, incl. zero depth, zero direction",
			corners_seen, boxes_seen);
		$display("and saturating offsets, with random stalls and a long output hold-off");
		if (errors == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
